### rtl/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
`default_nettype none

package bpfa_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam logic [7:0] USABLE_TYPE = 8'd7;

  typedef enum logic [1:0] {
    FN_RELEASE = 2'd0,
    FN_RESERVE = 2'd1,
    FN_ALLOC   = 2'd2,
    FN_FREE    = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  region_type;
    logic [16:0] range_start;
    logic [16:0] range_end;
    logic [15:0] frame_number;
  } req_t;

  typedef struct packed {
    logic [15:0] alloc_frame;
    logic        alloc_ok;
  } result_t;

  typedef enum logic [1:0] {
    WOP_SET,
    WOP_CLEAR,
    WOP_ALLOC
  } word_op_t;

  typedef struct packed {
    word_op_t         op;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } word_ctl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD,
    S_GRANT
  } state_t;

endpackage

`default_nettype wire

### rtl/bpfa_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bpfa_word_unit.sv
// Shared word unit: range mask, set/clear of a bitmap word, lowest free bit pick.
`default_nettype none

module bpfa_word_unit import bpfa_pkg::*; (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire word_ctl_t            ctl,
  output logic      [WORD_BITS-1:0] new_word,
  output logic      [WORD_BITS-1:0] onehot,
  output logic                      found
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;

  always_comb begin
    mask   = ({WORD_BITS{1'b1}} << ctl.lo) &
             ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - ctl.hi));
    avail  = ~word & mask;
    onehot = avail & (~avail + WORD_BITS'(1));
    found  = |avail;
    case (ctl.op)
      WOP_SET:   new_word = word | mask;
      WOP_CLEAR: new_word = word & ~mask;
      default:   new_word = word | onehot;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bitmap_page_frame_allocator.sv
// Bitmap page frame allocator: one used bit per frame, first-fit allocate.
// After reset the block runs a clearing pass that marks every frame used,
// one 64-frame word per cycle, and holds busy high meanwhile; cfg writes are
// taken at any time. A request is taken when start is high and busy is low.
// Release, reserve and free handle each 64-frame word touched with a RAM
// read, then a modify and write back through the shared word unit. Allocate
// scans the same way from word 0 up to the first word holding a free frame,
// then encodes the granted frame in S_GRANT. Requests that change nothing
// (wrong region type, empty range, freeing frame 0 or a frame past the store,
// frame_count of 0) finish without raising busy. Every request gives one
// result, shown for exactly one cycle with done high in the first cycle in
// which busy is low after the request; the receiver cannot stall it.
`default_nettype none

module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int NUM_FRAMES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire req_t        req,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_data,
  output logic             done,
  output result_t          result
);

  localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW = $clog2(NUM_FRAMES + 1);
  localparam int XW = (FW > 17) ? FW : 17;
  localparam logic [XW-1:0] NF = XW'(NUM_FRAMES);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  state_t               state, state_next;
  logic [AW-1:0]        w, w_next;
  logic [AW-1:0]        w_last, w_last_next;
  logic [BIT_W-1:0]     lo_first, lo_first_next;
  logic [BIT_W-1:0]     hi_last, hi_last_next;
  logic                 first, first_next;
  word_op_t             op, op_next;
  logic [WORD_BITS-1:0] onehot, onehot_next;
  logic [16:0]          frame_count;
  logic                 done_next;
  result_t              result_next;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  word_ctl_t            ctl;
  logic [WORD_BITS-1:0] unit_word;
  logic [WORD_BITS-1:0] unit_onehot;
  logic                 unit_found;

  logic [XW-1:0]        start_c, end_c, lim_c, fn_x, lo_v, hi_v;
  logic                 go;
  word_op_t             go_op;
  logic [BIT_W-1:0]     bit_idx;
  logic [XW-1:0]        grant_frame;

  bpfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(w),
    .wdata(ram_wdata),
    .raddr(w),
    .rdata(ram_rdata)
  );

  bpfa_word_unit u_unit (
    .word    (ram_rdata),
    .ctl     (ctl),
    .new_word(unit_word),
    .onehot  (unit_onehot),
    .found   (unit_found)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl.op = op;
    ctl.lo = first ? lo_first : '0;
    ctl.hi = (w == w_last) ? hi_last : BIT_W'(WORD_BITS - 1);
  end

  // request decode into a word span and an inclusive bit range
  always_comb begin
    start_c = (XW'(req.range_start) > NF) ? NF : XW'(req.range_start);
    end_c   = (XW'(req.range_end) > NF) ? NF : XW'(req.range_end);
    lim_c   = (XW'(frame_count) > NF) ? NF : XW'(frame_count);
    fn_x    = XW'(req.frame_number);
    go      = 1'b0;
    go_op   = WOP_CLEAR;
    lo_v    = start_c;
    hi_v    = end_c - XW'(1);
    unique case (req.func)
      FN_RELEASE: begin
        go = (req.region_type == USABLE_TYPE) && (start_c < end_c);
      end
      FN_RESERVE: begin
        go    = (start_c < end_c);
        go_op = WOP_SET;
      end
      FN_ALLOC: begin
        go    = (lim_c != '0);
        go_op = WOP_ALLOC;
        lo_v  = '0;
        hi_v  = lim_c - XW'(1);
      end
      FN_FREE: begin
        go   = (fn_x != '0) && (fn_x < NF);
        lo_v = fn_x;
        hi_v = fn_x;
      end
      default: ;
    endcase
  end

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
    grant_frame = XW'({w, bit_idx});
  end

  always_comb begin
    state_next    = state;
    w_next        = w;
    w_last_next   = w_last;
    lo_first_next = lo_first;
    hi_last_next  = hi_last;
    first_next    = first;
    op_next       = op;
    onehot_next   = onehot;
    done_next     = 1'b0;
    result_next   = result;
    ram_we        = 1'b0;
    ram_wdata     = unit_word;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (w == LAST_WORD) begin
          state_next = S_IDLE;
          w_next     = '0;
        end else begin
          w_next = w + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          if (go) begin
            state_next    = S_READ;
            op_next       = go_op;
            w_next        = lo_v[AW+BIT_W-1:BIT_W];
            w_last_next   = hi_v[AW+BIT_W-1:BIT_W];
            lo_first_next = lo_v[BIT_W-1:0];
            hi_last_next  = hi_v[BIT_W-1:0];
            first_next    = 1'b1;
          end else begin
            done_next   = 1'b1;
            result_next = '0;
          end
        end
      end
      S_READ: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        ram_we     = 1'b1;
        first_next = 1'b0;
        if (op == WOP_ALLOC && unit_found) begin
          state_next  = S_GRANT;
          onehot_next = unit_onehot;
        end else if (w == w_last) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '0;
        end else begin
          state_next = S_READ;
          w_next     = w + AW'(1);
        end
      end
      S_GRANT: begin
        state_next            = S_IDLE;
        done_next             = 1'b1;
        result_next.alloc_frame = grant_frame[15:0];
        result_next.alloc_ok    = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      w           <= '0;
      done        <= 1'b0;
      frame_count <= '0;
    end else begin
      state <= state_next;
      w     <= w_next;
      done  <= done_next;
      if (cfg_we) begin
        frame_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_last   <= w_last_next;
    lo_first <= lo_first_next;
    hi_last  <= hi_last_next;
    first    <= first_next;
    op       <= op_next;
    onehot   <= onehot_next;
    result   <= result_next;
  end

endmodule

`default_nettype wire

### rtl/bpfa_checker.sv
// Port-level checker for the bitmap page frame allocator, bound to the top level.
`default_nettype none

module bpfa_checker import bpfa_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire req_t        req,
  input wire logic        busy,
  input wire logic        cfg_we,
  input wire logic [16:0] cfg_data,
  input wire logic        done,
  input wire result_t     result
);

  // results come out only while the block is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.alloc_ok |-> result.alloc_frame == '0)
    else $error("failed or non-allocate result carries a frame");

  a_bad_type: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.func == FN_RELEASE && req.region_type != USABLE_TYPE
    |=> done && !busy && !result.alloc_ok)
    else $error("release of non-usable region did not finish at once");

  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.func != FN_ALLOC |=> !(done && result.alloc_ok))
    else $error("grant reported for a non-allocate request");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);

`default_nettype wire

### tb/tb_bitmap_page_frame_allocator.sv
// Testbench for the bitmap page frame allocator: directed and random requests checked against a model.
module tb_bitmap_page_frame_allocator import bpfa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES   = 65536;
  localparam int MAP_WORDS    = NUM_FRAMES / 64;
  localparam int RESERVED_LOW = 512;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_data = '0;
  logic        done;
  result_t     result;

  // model state
  logic [63:0] used_words [MAP_WORDS];
  logic [16:0] frame_limit;
  result_t     grant_q [$];
  int          live_frames [$];
  int          error_count = 0;
  int          sender_idle = 0;
  int          stall_cycles = 0;

  bitmap_page_frame_allocator #(.NUM_FRAMES(NUM_FRAMES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (used_words[i]) used_words[i] = '1;
    frame_limit = '0;
  end

  function automatic void flag_error(string msg);
    if (error_count < 10) $display("%0t ERROR %s", $time, msg);
    error_count++;
  endfunction

  function automatic void mark_frames(logic [16:0] first, logic [16:0] last, logic val);
    int lo;
    int hi;
    lo = (first > NUM_FRAMES) ? NUM_FRAMES : int'(first);
    hi = (last > NUM_FRAMES) ? NUM_FRAMES : int'(last);
    for (int f = lo; f < hi; f++) used_words[f >> 6][f & 63] = val;
  endfunction

  // applies one request to the model bitmap and returns the result it gives
  function automatic result_t predict_frame_op(req_t r);
    result_t     res;
    int          lim;
    int          left;
    logic [63:0] avail;
    res = '0;
    case (r.func)
      FN_RELEASE: if (r.region_type == USABLE_TYPE) mark_frames(r.range_start, r.range_end, 1'b0);
      FN_RESERVE: mark_frames(r.range_start, r.range_end, 1'b1);
      FN_ALLOC: begin
        lim = (frame_limit > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
        for (int w = 0; w < MAP_WORDS && w * 64 < lim && !res.alloc_ok; w++) begin
          avail = ~used_words[w];
          left = lim - w * 64;
          if (left < 64) avail &= (64'd1 << left) - 64'd1;
          for (int b = 0; b < 64 && !res.alloc_ok; b++) begin
            if (avail[b]) begin
              used_words[w][b] = 1'b1;
              res.alloc_ok = 1'b1;
              res.alloc_frame = 16'(w * 64 + b);
              live_frames.push_back(w * 64 + b);
            end
          end
        end
      end
      FN_FREE: begin
        if (r.frame_number != 0) used_words[r.frame_number[15:6]][r.frame_number[5:0]] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (done) begin
        if (grant_q.size() == 0) begin
          flag_error($sformatf("result with none pending: frame %0h ok %0b",
                               result.alloc_frame, result.alloc_ok));
        end else begin
          want = grant_q.pop_front();
          if (result.alloc_frame !== want.alloc_frame)
            flag_error($sformatf("alloc_frame expected %0h got %0h",
                                 want.alloc_frame, result.alloc_frame));
          if (result.alloc_ok !== want.alloc_ok)
            flag_error($sformatf("alloc_ok expected %0b got %0b", want.alloc_ok, result.alloc_ok));
        end
      end
      if (cfg_we) frame_limit = cfg_data;
      if (start && !busy) grant_q.push_back(predict_frame_op(req));
    end
  end

  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_bitmap_page_frame_allocator: done, errors");
      $finish;
    end
  end

  task automatic send_req(input req_t r);
    if (sender_idle != 0 && $urandom_range(0, 99) < sender_idle) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [16:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t make_req(func_t f, logic [7:0] rtype, int first, int last, int frame);
    req_t r;
    r.func = f;
    r.region_type = rtype;
    r.range_start = first[16:0];
    r.range_end = last[16:0];
    r.frame_number = frame[15:0];
    return r;
  endfunction

  function automatic req_t random_req();
    return make_req(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 131071), $urandom_range(0, 131071),
                    $urandom_range(0, 65535));
  endfunction

  // mostly short low ranges; some empty, past the store or wide
  function automatic req_t with_random_range(req_t r);
    int pick;
    int first;
    int last;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      first = $urandom_range(0, 16383);
      last = first + $urandom_range(0, 256);
    end else if (pick < 88) begin
      first = $urandom_range(1, 65536);
      last = $urandom_range(0, first - 1);
    end else if (pick < 95) begin
      first = $urandom_range(65000, 131071);
      last = $urandom_range(first, 131071);
    end else begin
      first = $urandom_range(0, 65535);
      last = $urandom_range(first, 65536);
    end
    r.range_start = first[16:0];
    r.range_end = last[16:0];
    return r;
  endfunction

  task automatic test_count_zero();
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    send_req(make_req(FN_RELEASE, USABLE_TYPE, 0, 1, 0));
    set_frame_count(17'd1);
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
  endtask

  task automatic test_region_types();
    send_req(make_req(FN_RELEASE, 8'd0, 512, 1024, 0));
    send_req(make_req(FN_RELEASE, 8'd6, 512, 1024, 0));
    send_req(make_req(FN_RELEASE, 8'hFF, 512, 1024, 0));
    set_frame_count(17'h10000);
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
  endtask

  task automatic test_ranges();
    send_req(make_req(FN_RELEASE, USABLE_TYPE, 0, 4096, 0));
    send_req(make_req(FN_RELEASE, USABLE_TYPE, 8192, 65536, 0));
    send_req(make_req(FN_RELEASE, USABLE_TYPE, 65436, 131071, 0));
    send_req(make_req(FN_RELEASE, USABLE_TYPE, 3000, 200, 0));
    send_req(make_req(FN_RESERVE, 8'd0, 65536, 131071, 0));
    send_req(make_req(FN_RESERVE, 8'd0, 0, RESERVED_LOW, 0));
  endtask

  task automatic test_alloc_free();
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    send_req(make_req(FN_FREE, 8'd0, 0, 0, 512));
    send_req(make_req(FN_FREE, 8'd0, 0, 0, 0));
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    set_frame_count(17'd600);
    send_req(make_req(FN_RESERVE, 8'd0, 512, 4096, 0));
    send_req(make_req(FN_FREE, 8'd0, 0, 0, 599));
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    send_req(make_req(FN_FREE, 8'd0, 0, 0, 650));
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    set_frame_count(COUNT_MAX);
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    send_req(make_req(FN_RESERVE, 8'd0, 0, 131071, 0));
    send_req(make_req(FN_FREE, 8'd0, 0, 0, 65535));
    send_req(make_req(FN_ALLOC, 8'd0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic run_random_phase(input int items, input int idle, input logic [16:0] count);
    req_t r;
    int   pick;
    int   idx;
    set_frame_count(count);
    sender_idle = idle;
    // bring-up: usable regions released, then the low frames reserved
    repeat ($urandom_range(1, 4)) begin
      r = with_random_range(random_req());
      r.func = FN_RELEASE;
      r.region_type = USABLE_TYPE;
      send_req(r);
    end
    r = random_req();
    r.func = FN_RESERVE;
    r.range_start = '0;
    r.range_end = 17'(RESERVED_LOW);
    send_req(r);
    for (int i = 0; i < items; i++) begin
      r = random_req();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.func = FN_ALLOC;
      end else if (pick < 75) begin
        r.func = FN_FREE;
        if (live_frames.size() != 0 && $urandom_range(0, 1)) begin
          idx = $urandom_range(0, live_frames.size() - 1);
          r.frame_number = 16'(live_frames[idx]);
          live_frames.delete(idx);
        end else if ($urandom_range(0, 9) == 0) begin
          r.frame_number = '0;
        end
      end else if (pick < 88) begin
        r = with_random_range(r);
        r.func = FN_RELEASE;
        if ($urandom_range(0, 1)) r.region_type = USABLE_TYPE;
      end else begin
        r = with_random_range(r);
        r.func = FN_RESERVE;
      end
      if ($urandom_range(0, 99) < 2) wait_drained();
      send_req(r);
    end
  endtask

  task automatic test_random_traffic();
    int          idle_pct [8] = '{0, 71, 21, 0, 71, 21, 71, 0};
    logic [16:0] counts [8];
    counts = '{17'h10000, COUNT_MAX, 17'd700, 17'd0, 17'd1, 17'd65535, 17'd64,
               17'($urandom_range(0, 131071))};
    for (int p = 0; p < 8; p++) run_random_phase(100, idle_pct[p], counts[p]);
    sender_idle = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_count_zero();
    test_region_types();
    test_ranges();
    test_alloc_free();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk);
    if (error_count == 0 && grant_q.size() == 0) begin
      $display("tb_bitmap_page_frame_allocator: done, clean");
    end else begin
      $display("tb_bitmap_page_frame_allocator: done, errors");
    end
    $finish;
  end

endmodule
